>>> hw/rtl/msc_pkg.sv
// Shared types, constants and opcode names for the MIPS subset core.
`default_nettype none
package msc_pkg;
  localparam int DATA_WORDS_DEF = 1024;
  localparam logic [31:0] DATA_BASE = 32'h1000_0000;
  localparam logic [31:0] GP_RESET = 32'h1000_8000;
  localparam logic [31:0] START_PC_RESET = 32'h0040_0000;
  localparam logic [31:0] HI_MASK = 32'hF000_0000;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J = 6'h02;
  localparam logic [5:0] OP_JAL = 6'h03;
  localparam logic [5:0] OP_BEQ = 6'h04;
  localparam logic [5:0] OP_BNE = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_ANDI = 6'h0c;
  localparam logic [5:0] OP_LUI = 6'h0f;
  localparam logic [5:0] OP_TRAP = 6'h1a;
  localparam logic [5:0] OP_LW = 6'h23;
  localparam logic [5:0] OP_SW = 6'h2b;

  localparam logic [5:0] FN_SLL = 6'h00;
  localparam logic [5:0] FN_SRA = 6'h03;
  localparam logic [5:0] FN_JR = 6'h08;
  localparam logic [5:0] FN_MFHI = 6'h10;
  localparam logic [5:0] FN_MFLO = 6'h12;
  localparam logic [5:0] FN_MULT = 6'h18;
  localparam logic [5:0] FN_DIV = 6'h1a;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_SLT = 6'h2a;

  localparam logic [3:0] TR_NEWLINE = 4'h0;
  localparam logic [3:0] TR_PRINT = 4'h1;
  localparam logic [3:0] TR_READ = 4'h5;
  localparam logic [3:0] TR_HALT = 4'ha;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_NEWLINE = 2'd1;
  localparam logic [1:0] ACT_PRINT = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  typedef enum logic [1:0] {MD_IDLE, MD_RUN, MD_DONE} md_state_t;
  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MEM, ST_MULDIV, ST_OUT
  } core_state_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;
endpackage
`default_nettype wire

>>> hw/rtl/msc_muldiv.sv
// Iterative signed multiply and divide unit, one bit per cycle.
`default_nettype none
module msc_muldiv
  import msc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire md_ctrl_t    ctrl,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      hi,
  output logic [31:0]      lo
);
  md_state_t state, state_next;
  logic [5:0] count;
  logic is_div, neg_q, neg_r;
  logic [31:0] mag_b;
  logic [31:0] acc;
  logic [31:0] shreg;
  logic [32:0] trial;
  logic [32:0] radd;
  logic [63:0] prod, prod_neg;
  logic [31:0] q_fix, r_fix;

  assign trial = {acc, shreg[31]} - {1'b0, mag_b};
  assign radd = {1'b0, acc} + ({33{shreg[0]}} & {1'b0, mag_b});

  always_comb begin
    state_next = state;
    case (state)
      MD_IDLE: if (ctrl.start) state_next = MD_RUN;
      MD_RUN:  if (count == 6'd31) state_next = MD_DONE;
      MD_DONE: state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == MD_RUN) count <= count + 6'd1;
      else count <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: if (ctrl.start) begin
        is_div <= ctrl.is_div;
        acc <= '0;
        if (ctrl.is_div) begin
          neg_q <= a[31] ^ b[31];
          neg_r <= a[31];
          shreg <= a[31] ? (~a + 32'd1) : a;
          mag_b <= b[31] ? (~b + 32'd1) : b;
        end else begin
          neg_q <= a[31] ^ b[31];
          neg_r <= 1'b0;
          shreg <= a[31] ? (~a + 32'd1) : a;
          mag_b <= b[31] ? (~b + 32'd1) : b;
        end
      end
      MD_RUN: begin
        if (is_div) begin
          if (!trial[32]) begin
            acc <= trial[31:0];
            shreg <= {shreg[30:0], 1'b1};
          end else begin
            acc <= {acc[30:0], shreg[31]};
            shreg <= {shreg[30:0], 1'b0};
          end
        end else begin
          acc <= radd[32:1];
          shreg <= {radd[0], shreg[31:1]};
        end
      end
      default: ;
    endcase
  end

  assign prod = {acc, shreg};
  assign prod_neg = ~prod + 64'd1;
  assign q_fix = neg_q ? (~shreg + 32'd1) : shreg;
  assign r_fix = neg_r ? (~acc + 32'd1) : acc;

  assign done = (state == MD_DONE);
  always_comb begin
    if (is_div) begin
      hi = r_fix;
      lo = q_fix;
    end else begin
      hi = neg_q ? prod_neg[63:32] : prod[63:32];
      lo = neg_q ? prod_neg[31:0] : prod[31:0];
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/mips_subset_core_unit.sv
// Top level of the MIPS subset core: sequencer, register file, data memory.
// Usage:
//   Input channel (instr_valid/instr_stall) carries instr_word and
//   console_input, one instruction per beat, fetched at the current pc.
//   Output channel (out_valid/out_stall) returns one beat per instruction:
//   next_pc, console_action, console_value, halted, unimplemented.
//   After acceptance the core steps through operand read (ST_READ) and
//   execute (ST_EXEC) before out_valid rises in ST_OUT. lw adds ST_MEM
//   for the registered memory read. mult and div by a nonzero divisor run
//   in a shared shift-add/subtract unit, one bit per cycle, and then a
//   done state in that unit before the result beat.
//   One instruction is in flight; instr_stall is high until the result beat
//   has been taken. A stalled result holds steady.
//   Register file lives in a 32-entry memory with one read port used twice.
//   rst resets pc to START_PC_RESET, registers to zero except gp and sp,
//   hi/lo to zero and clears the halt flag. Data memory is not cleared.
//   After rst the register sweep keeps instr_stall high until it ends.
//   start_pc_we loads the pc from start_pc_wdata; write only when idle.
//   After halt, each instruction returns the held pc with halted set.
`default_nettype none
module mips_subset_core_unit
  import msc_pkg::*;
#(
  parameter int DATA_WORDS = DATA_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start_pc_we,
  input  wire logic [31:0] start_pc_wdata,
  input  wire logic        instr_valid,
  output logic             instr_stall,
  input  wire logic [31:0] instr_word,
  input  wire logic [31:0] console_input,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      next_pc,
  output logic [1:0]       console_action,
  output logic [31:0]      console_value,
  output logic             halted,
  output logic             unimplemented
);
  localparam int AW = $clog2(DATA_WORDS);

  core_state_t state, state_next;
  logic [31:0] pc, ir, cin, a, b, wb_val, mem_q, hi_word, lo_word;
  logic [31:0] regs [32];
  logic [31:0] dmem [DATA_WORDS];
  logic        rd_phase, halt_flag;
  logic [4:0]  rd_addr, wb_reg;
  logic [31:0] rd_data;
  logic        wb_en;
  logic        rst_done;
  logic [4:0]  rst_idx;
  md_ctrl_t    md_ctrl;
  logic        md_done;
  logic [31:0] md_hi, md_lo;

  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sh;
  logic [31:0] uimm, simm, npc4, ea, off;
  logic        in_range;

  assign op = ir[31:26];
  assign rs = ir[25:21];
  assign rt = ir[20:16];
  assign rd = ir[15:11];
  assign sh = ir[10:6];
  assign fn = ir[5:0];
  assign uimm = {16'd0, ir[15:0]};
  assign simm = {{16{ir[15]}}, ir[15:0]};
  assign npc4 = pc + 32'd4;
  assign ea = a + simm;
  assign off = ea - DATA_BASE;
  assign in_range = (off[31:2] < 30'(DATA_WORDS));

  // register file: reset sweep writes zeros and gp/sp presets
  // rs is read at the accepting edge, rt in the cycle after
  assign rd_addr = rd_phase ? rt : ((state == ST_IDLE) ? instr_word[25:21] : rs);
  always_ff @(posedge clk) begin
    rd_data <= regs[rd_addr];
    if (!rst_done) begin
      if (rst_idx == 5'd28) regs[rst_idx] <= GP_RESET;
      else if (rst_idx == 5'd29) regs[rst_idx] <= DATA_BASE + 32'(DATA_WORDS * 4);
      else regs[rst_idx] <= '0;
    end else if (wb_en && wb_reg != 5'd0) begin
      regs[wb_reg] <= wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rst_done <= 1'b0;
      rst_idx <= '0;
    end else if (!rst_done) begin
      rst_idx <= rst_idx + 5'd1;
      if (rst_idx == 5'd31) rst_done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= dmem[off[AW+1:2]];
    if (state == ST_EXEC && !halt_flag && op == OP_SW && in_range)
      dmem[off[AW+1:2]] <= b;
  end

  msc_muldiv u_md (
    .clk(clk), .rst(rst), .ctrl(md_ctrl), .a(a), .b(b),
    .done(md_done), .hi(md_hi), .lo(md_lo)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (instr_valid && rst_done) state_next = ST_READ;
      ST_READ: state_next = ST_EXEC;
      ST_EXEC: begin
        if (halt_flag) state_next = ST_OUT;
        else if (op == OP_LW) state_next = ST_MEM;
        else if (op == OP_SPECIAL && (fn == FN_MULT || (fn == FN_DIV && b != 0)))
          state_next = ST_MULDIV;
        else state_next = ST_OUT;
      end
      ST_MEM: state_next = ST_OUT;
      ST_MULDIV: if (md_done) state_next = ST_OUT;
      ST_OUT: if (!out_stall) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    instr_stall = !(state == ST_IDLE && rst_done);
    out_valid = (state == ST_OUT);
    md_ctrl.start = (state == ST_EXEC) && (state_next == ST_MULDIV);
    md_ctrl.is_div = (fn == FN_DIV);
  end

  // capture A after the rs read
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && instr_valid) begin
      ir <= instr_word;
      cin <= console_input;
    end
    if (state == ST_READ) a <= rd_data;
  end

  assign b = rd_data;

  logic [31:0] res, npc;
  logic [4:0]  dst;
  logic        we;
  logic [1:0]  act;
  logic [31:0] val;
  logic        unimpl, halt_set;

  always_comb begin
    res = '0; dst = rd; we = 1'b0; npc = npc4;
    act = ACT_NONE; val = '0; unimpl = 1'b0; halt_set = 1'b0;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL: begin res = b << sh; we = 1'b1; end
          FN_SRA: begin res = $signed(b) >>> sh; we = 1'b1; end
          FN_JR: npc = a;
          FN_MFHI: begin res = hi_word; we = 1'b1; end
          FN_MFLO: begin res = lo_word; we = 1'b1; end
          FN_MULT, FN_DIV: ;
          FN_ADDU: begin res = a + b; we = 1'b1; end
          FN_SUBU: begin res = a - b; we = 1'b1; end
          FN_SLT: begin res = {31'd0, $signed(a) < $signed(b)}; we = 1'b1; end
          default: unimpl = 1'b1;
        endcase
      end
      OP_J: npc = (npc4 & HI_MASK) | {4'd0, ir[25:0], 2'b00};
      OP_JAL: begin
        res = npc4; dst = 5'd31; we = 1'b1;
        npc = (npc4 & HI_MASK) | {4'd0, ir[25:0], 2'b00};
      end
      OP_BEQ: if (a == b) npc = npc4 + {simm[29:0], 2'b00};
      OP_BNE: if (a != b) npc = npc4 + {simm[29:0], 2'b00};
      OP_ADDIU: begin res = ea; dst = rt; we = 1'b1; end
      OP_ANDI: begin res = a & uimm; dst = rt; we = 1'b1; end
      OP_LUI: begin res = {ir[15:0], 16'd0}; dst = rt; we = 1'b1; end
      OP_TRAP: begin
        case (ir[3:0])
          TR_NEWLINE: act = ACT_NEWLINE;
          TR_PRINT: begin act = ACT_PRINT; val = a; end
          TR_READ: begin act = ACT_READ; res = cin; dst = rt; we = 1'b1; end
          TR_HALT: halt_set = 1'b1;
          default: begin unimpl = 1'b1; halt_set = 1'b1; end
        endcase
      end
      OP_LW: dst = rt;
      OP_SW: ;
      default: unimpl = 1'b1;
    endcase
  end

  logic [31:0] exec_val;
  assign exec_val = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc <= START_PC_RESET;
      hi_word <= '0;
      lo_word <= '0;
      halt_flag <= 1'b0;
      rd_phase <= 1'b0;
      wb_en <= 1'b0;
      next_pc <= '0;
      console_action <= ACT_NONE;
      console_value <= '0;
      halted <= 1'b0;
      unimplemented <= 1'b0;
    end else begin
      state <= state_next;
      wb_en <= 1'b0;
      rd_phase <= (state == ST_IDLE && instr_valid && rst_done);
      if (start_pc_we) pc <= start_pc_wdata;
      if (state == ST_EXEC) begin
        if (halt_flag) begin
          next_pc <= pc;
          console_action <= ACT_NONE;
          console_value <= '0;
          halted <= 1'b1;
          unimplemented <= 1'b0;
        end else begin
          pc <= npc;
          next_pc <= npc;
          console_action <= act;
          console_value <= val;
          halted <= halt_set;
          unimplemented <= unimpl;
          if (halt_set) halt_flag <= 1'b1;
          wb_reg <= dst;
          if (op == OP_LW) begin
            wb_en <= 1'b0;
          end else begin
            wb_en <= we;
            wb_val <= exec_val;
          end
          if (op == OP_SPECIAL && fn == FN_DIV && b == 32'd0) begin
            lo_word <= 32'hFFFF_FFFF;
            hi_word <= a;
          end
        end
      end
      if (state == ST_MEM) begin
        wb_en <= 1'b1;
        wb_val <= in_range ? mem_q : 32'd0;
      end
      if (state == ST_MULDIV && md_done) begin
        hi_word <= md_hi;
        lo_word <= md_lo;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/msc_checker.sv
// Port-level checks for the MIPS subset core, bound to the top level.
`default_nettype none
module msc_checker
  import msc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        instr_valid,
  input wire logic        instr_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] next_pc,
  input wire logic [1:0]  console_action,
  input wire logic        halted
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(next_pc))
    else $error("result beat changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> instr_stall)
    else $error("input accepted while result pending");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted dropped without reset");
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> console_action == ACT_NONE)
    else $error("console action while halted");
  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    instr_valid && !instr_stall |=> instr_stall)
    else $error("second beat taken while busy");
endmodule

bind mips_subset_core_unit msc_checker u_msc_checker (
  .clk(clk), .rst(rst), .instr_valid(instr_valid), .instr_stall(instr_stall),
  .out_valid(out_valid), .out_stall(out_stall), .next_pc(next_pc),
  .console_action(console_action), .halted(halted)
);
`default_nettype wire

>>> sim/mips_subset_core_unit_tb.sv
// Self-checking testbench for mips_subset_core_unit: directed and random instruction streams.
`default_nettype none
module mips_subset_core_unit_tb;
  import msc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] npc;
    logic [1:0]  act;
    logic [31:0] val;
    logic        halt;
    logic        unimpl;
  } core_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start_pc_we = 1'b0;
  logic [31:0] start_pc_wdata = '0;
  logic        instr_valid = 1'b0;
  logic        instr_stall;
  logic [31:0] instr_word = '0;
  logic [31:0] console_input = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] next_pc;
  logic [1:0]  console_action;
  logic [31:0] console_value;
  logic        halted;
  logic        unimplemented;

  mips_subset_core_unit uut (
    .clk(clk), .rst(rst),
    .start_pc_we(start_pc_we), .start_pc_wdata(start_pc_wdata),
    .instr_valid(instr_valid), .instr_stall(instr_stall),
    .instr_word(instr_word), .console_input(console_input),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_pc(next_pc), .console_action(console_action),
    .console_value(console_value), .halted(halted), .unimplemented(unimplemented)
  );

  // architectural shadow state
  logic [31:0] arch_regs [32];
  logic [31:0] hi_word, lo_word, arch_pc, start_pc;
  logic [31:0] data_words [DATA_WORDS_DEF];
  logic        word_written [DATA_WORDS_DEF];
  logic        core_halted;

  core_result_t pending_results[$];
  int beats_checked = 0;
  int mismatches = 0;
  int burst_left = 0;
  int cyc = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] trap(logic [3:0] code, logic [4:0] rs, logic [4:0] rt);
    return {OP_TRAP, rs, rt, 12'h000, code};
  endfunction

  function automatic void write_reg(logic [4:0] r, logic [31:0] v);
    if (r != 5'd0) arch_regs[r] = v;
  endfunction

  function automatic logic [31:0] word_index(logic [31:0] addr);
    return (addr - DATA_BASE) >> 2;
  endfunction

  task automatic execute_instr(input logic [31:0] w, input logic [31:0] cin,
                               output core_result_t r);
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] simm, a, b, npc, idx;
    longint      x, y, p;
    r = '0;
    if (!core_halted) begin
      op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11]; sh = w[10:6]; fn = w[5:0];
      simm = {{16{w[15]}}, w[15:0]};
      a = arch_regs[rs]; b = arch_regs[rt];
      npc = arch_pc + 32'd4;
      case (op)
        OP_SPECIAL: case (fn)
          FN_SLL:  write_reg(rd, b << sh);
          FN_SRA:  write_reg(rd, $signed(b) >>> sh);
          FN_JR:   npc = a;
          FN_MFHI: write_reg(rd, hi_word);
          FN_MFLO: write_reg(rd, lo_word);
          FN_MULT: begin
            p = longint'($signed(a)) * longint'($signed(b));
            {hi_word, lo_word} = p;
          end
          FN_DIV: begin
            if (b == 32'd0) begin
              lo_word = 32'hFFFF_FFFF;
              hi_word = a;
            end else begin
              x = longint'($signed(a));
              y = longint'($signed(b));
              lo_word = 32'(x / y);
              hi_word = 32'(x % y);
            end
          end
          FN_ADDU: write_reg(rd, a + b);
          FN_SUBU: write_reg(rd, a - b);
          FN_SLT:  write_reg(rd, ($signed(a) < $signed(b)) ? 32'd1 : 32'd0);
          default: r.unimpl = 1'b1;
        endcase
        OP_J:   npc = {npc[31:28], w[25:0], 2'b00};
        OP_JAL: begin
          write_reg(5'd31, npc);
          npc = {npc[31:28], w[25:0], 2'b00};
        end
        OP_BEQ:   if (a == b) npc = npc + (simm << 2);
        OP_BNE:   if (a != b) npc = npc + (simm << 2);
        OP_ADDIU: write_reg(rt, a + simm);
        OP_ANDI:  write_reg(rt, a & {16'h0, w[15:0]});
        OP_LUI:   write_reg(rt, {w[15:0], 16'h0});
        OP_TRAP: case (w[3:0])
          TR_NEWLINE: r.act = ACT_NEWLINE;
          TR_PRINT: begin
            r.act = ACT_PRINT;
            r.val = a;
          end
          TR_READ: begin
            r.act = ACT_READ;
            write_reg(rt, cin);
          end
          TR_HALT: core_halted = 1'b1;
          default: begin
            r.unimpl = 1'b1;
            core_halted = 1'b1;
          end
        endcase
        OP_LW: begin
          idx = word_index(a + simm);
          write_reg(rt, (idx < DATA_WORDS_DEF) ? data_words[idx] : 32'd0);
        end
        OP_SW: begin
          idx = word_index(a + simm);
          if (idx < DATA_WORDS_DEF) begin
            data_words[idx] = b;
            word_written[idx] = 1'b1;
          end
        end
        default: r.unimpl = 1'b1;
      endcase
      arch_pc = npc;
    end
    r.npc = arch_pc;
    r.halt = core_halted;
  endtask

  task automatic send_beat(input logic [31:0] w, input logic [31:0] cin);
    core_result_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        instr_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    instr_valid <= 1'b1;
    instr_word <= w;
    console_input <= cin;
    do @(posedge clk); while (instr_stall);
    execute_instr(w, cin, r);
    pending_results.push_back(r);
  endtask

  task automatic send(input logic [31:0] w);
    send_beat(w, $urandom());
  endtask

  task automatic drain();
    instr_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start_pc(input logic [31:0] v);
    drain();
    start_pc_we <= 1'b1;
    start_pc_wdata <= v;
    @(posedge clk);
    start_pc_we <= 1'b0;
    start_pc = v;
    arch_pc = v;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    core_result_t e;
    cyc <= cyc + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, pc %h", next_pc);
      end else begin
        e = pending_results.pop_front();
        beats_checked++;
        if (next_pc !== e.npc || console_action !== e.act || console_value !== e.val ||
            halted !== e.halt || unimplemented !== e.unimpl) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp pc %h act %0d val %h halt %b unimpl %b / got %h %0d %h %b %b",
                     e.npc, e.act, e.val, e.halt, e.unimpl,
                     next_pc, console_action, console_value, halted, unimplemented);
        end
      end
    end
    case (cyc[9:8])
      2'd0: out_stall <= 1'b0;
      2'd1: out_stall <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (cyc[5:0] < 6'd40);
    endcase
  end

  function automatic logic [4:0] dest_reg();
    logic [4:0] d;
    d = 5'($urandom_range(1, 31));
    return (d == 5'd28) ? 5'd27 : d;
  endfunction

  function automatic logic [31:0] random_instr();
    logic [31:0] w, idx;
    logic [5:0]  fns [5];
    int k, sel;
    fns = '{FN_SLL, FN_SRA, FN_ADDU, FN_SUBU, FN_SLT};
    sel = $urandom_range(0, 99);
    k = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
    if (sel < 12)
      w = rtype(fns[$urandom_range(0, 4)], 5'($urandom()), 5'($urandom()), dest_reg(),
                5'($urandom()));
    else if (sel < 20)
      w = rtype($urandom_range(0, 1) ? FN_MULT : FN_DIV, 5'($urandom()), 5'($urandom()),
                5'($urandom()), 5'($urandom()));
    else if (sel < 26)
      w = rtype($urandom_range(0, 1) ? FN_MFHI : FN_MFLO, 5'd0, 5'd0, dest_reg(), 5'd0);
    else if (sel < 29) w = rtype(FN_JR, 5'($urandom()), 5'd0, 5'd0, 5'd0);
    else if (sel < 34) w = {$urandom_range(0, 1) ? OP_J : OP_JAL, 26'($urandom())};
    else if (sel < 42) begin
      w = itype($urandom_range(0, 1) ? OP_BEQ : OP_BNE, 5'($urandom()), 5'($urandom()),
                16'($urandom()));
      if ($urandom_range(0, 2) == 0) w[20:16] = w[25:21];
    end
    else if (sel < 54) w = itype(OP_ADDIU, 5'($urandom()), dest_reg(), 16'($urandom()));
    else if (sel < 60) w = itype(OP_ANDI, 5'($urandom()), dest_reg(), 16'($urandom()));
    else if (sel < 70) w = itype(OP_LUI, 5'($urandom()), dest_reg(), 16'($urandom()));
    else if (sel < 80) begin
      if ($urandom_range(0, 9) == 0)
        w = itype(OP_SW, 5'd28, 5'($urandom()), 16'h4000 + 16'($urandom_range(0, 16383)));
      else
        w = itype(OP_SW, 5'd28, 5'($urandom()), 16'h8000 + 16'(4 * k + $urandom_range(0, 3)));
    end
    else if (sel < 90) begin
      if (word_written[k])
        w = itype(OP_LW, 5'd28, dest_reg(), 16'h8000 + 16'(4 * k + $urandom_range(0, 3)));
      else
        w = itype(OP_LW, 5'd28, dest_reg(), 16'h4000 + 16'($urandom_range(0, 16383)));
    end
    else if (sel < 96) begin
      case ($urandom_range(0, 2))
        0: w = trap(TR_NEWLINE, 5'($urandom()), 5'($urandom()));
        1: w = trap(TR_PRINT, 5'($urandom()), 5'($urandom()));
        default: w = trap(TR_READ, 5'($urandom()), 5'($urandom()));
      endcase
      w[15:4] = 12'($urandom());
    end
    else w = $urandom();
    // keep the gp base, avoid halting, never load an unwritten word
    if (w[31:26] == OP_TRAP && !(w[3:0] inside {TR_NEWLINE, TR_PRINT, TR_READ}))
      w[3:0] = TR_PRINT;
    if (w[31:26] inside {OP_ADDIU, OP_ANDI, OP_LUI, OP_LW, OP_TRAP} && w[20:16] == 5'd28)
      w[20:16] = 5'd27;
    if (w[31:26] == OP_SPECIAL && w[15:11] == 5'd28) w[15:11] = 5'd27;
    if (w[31:26] == OP_LW) begin
      idx = word_index(arch_regs[w[25:21]] + {{16{w[15]}}, w[15:0]});
      if (idx < DATA_WORDS_DEF && !word_written[idx])
        w = itype(OP_LW, 5'd28, w[20:16], 16'h4000);
    end
    return w;
  endfunction

  task automatic test_reset_state();
    send(trap(TR_PRINT, 5'd28, 5'd0));
    send(trap(TR_PRINT, 5'd29, 5'd0));
    send(rtype(FN_MFHI, 5'd0, 5'd0, 5'd1, 5'd0));
  endtask

  task automatic test_arith();
    send(itype(OP_LUI, 5'd0, 5'd1, 16'h8000));
    send(itype(OP_ADDIU, 5'd1, 5'd2, 16'hFFFF));
    send(itype(OP_ADDIU, 5'd0, 5'd3, 16'hFFFF));
    send(itype(OP_ADDIU, 5'd0, 5'd4, 16'h7FFF));
    send(itype(OP_ANDI, 5'd3, 5'd5, 16'hFFFF));
    send(rtype(FN_SLL, 5'd0, 5'd3, 5'd6, 5'd31));
    send(rtype(FN_SRA, 5'd0, 5'd1, 5'd8, 5'd31));
    send(rtype(FN_SRA, 5'd0, 5'd2, 5'd9, 5'd4));
    send(rtype(FN_ADDU, 5'd2, 5'd4, 5'd10, 5'd0));
    send(rtype(FN_SUBU, 5'd1, 5'd4, 5'd11, 5'd0));
    send(rtype(FN_SLT, 5'd1, 5'd2, 5'd12, 5'd0));
    send(rtype(FN_SLT, 5'd2, 5'd1, 5'd0, 5'd0));
    send(rtype(FN_MULT, 5'd1, 5'd1, 5'd0, 5'd0));
    send(rtype(FN_MFHI, 5'd0, 5'd0, 5'd14, 5'd0));
    send(rtype(FN_DIV, 5'd1, 5'd3, 5'd0, 5'd0));
    send(rtype(FN_MFLO, 5'd0, 5'd0, 5'd15, 5'd0));
    send(rtype(FN_MFHI, 5'd0, 5'd0, 5'd16, 5'd0));
    send(rtype(FN_DIV, 5'd2, 5'd0, 5'd0, 5'd0));
    send(rtype(FN_MFLO, 5'd0, 5'd0, 5'd17, 5'd0));
    send(rtype(FN_MFHI, 5'd0, 5'd0, 5'd18, 5'd0));
    send(rtype(6'h3F, 5'd1, 5'd2, 5'd19, 5'd0));
    send(itype(6'h3F, 5'd1, 5'd2, 16'h1234));
  endtask

  task automatic test_console();
    send(trap(TR_NEWLINE, 5'd0, 5'd0));
    send(trap(TR_PRINT, 5'd1, 5'd0));
    send_beat(trap(TR_READ, 5'd0, 5'd20), 32'h8000_0000);
    send_beat(trap(TR_READ, 5'd0, 5'd0), 32'hFFFF_FFFF);
    send(trap(TR_PRINT, 5'd20, 5'd0));
  endtask

  task automatic test_control();
    send(itype(OP_BEQ, 5'd0, 5'd0, 16'hFFFF));
    send(itype(OP_BEQ, 5'd1, 5'd2, 16'h0010));
    send(itype(OP_BNE, 5'd1, 5'd2, 16'h7FFF));
    send(itype(OP_BNE, 5'd0, 5'd0, 16'h8000));
    send({OP_J, 26'h3FF_FFFF});
    send({OP_JAL, 26'h000_0000});
    send(rtype(FN_JR, 5'd3, 5'd0, 5'd0, 5'd0));
    send(rtype(FN_JR, 5'd31, 5'd0, 5'd0, 5'd0));
  endtask

  task automatic test_memory();
    send(itype(OP_SW, 5'd28, 5'd2, 16'h8000));
    send(itype(OP_LW, 5'd28, 5'd21, 16'h8003));
    send(itype(OP_SW, 5'd28, 5'd1, 16'h8FFC));
    send(itype(OP_LW, 5'd28, 5'd22, 16'h8FFC));
    send(itype(OP_SW, 5'd28, 5'd3, 16'h9000));
    send(itype(OP_LW, 5'd28, 5'd23, 16'h9000));
    send(itype(OP_LW, 5'd29, 5'd24, 16'h7FFF));
  endtask

  task automatic test_start_pc_sweep();
    logic [31:0] pcs [4];
    pcs = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFC, $urandom()};
    foreach (pcs[i]) begin
      write_start_pc(pcs[i]);
      send({OP_J, 26'($urandom())});
      send(itype(OP_BNE, 5'd1, 5'd0, 16'($urandom())));
      send(random_instr());
    end
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      send(random_instr());
      if (i == n / 2) drain();
    end
  endtask

  task automatic test_halt();
    if ($urandom_range(0, 1)) send(trap(TR_HALT, 5'd1, 5'd2));
    else send(trap(4'h3, 5'd1, 5'd2));
    repeat (5) send($urandom());
  endtask

  initial begin
    foreach (arch_regs[i]) arch_regs[i] = '0;
    arch_regs[28] = GP_RESET;
    arch_regs[29] = DATA_BASE + 32'(4 * DATA_WORDS_DEF);
    foreach (word_written[i]) word_written[i] = 1'b0;
    hi_word = '0;
    lo_word = '0;
    start_pc = START_PC_RESET;
    arch_pc = START_PC_RESET;
    core_halted = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_arith();
    test_console();
    test_control();
    test_memory();
    test_start_pc_sweep();
    test_random(700);
    write_start_pc($urandom());
    test_random(700);
    write_start_pc(START_PC_RESET);
    test_halt();
    drain();
    repeat (40) @(posedge clk);
    $display("Checked %0d result beats over directed, start pc sweep, random and halt phases",
             beats_checked);
    $display("Mismatches: %0d, results still owed: %0d", mismatches, pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
hw/rtl/msc_pkg.sv
hw/rtl/msc_muldiv.sv
hw/rtl/mips_subset_core_unit.sv
hw/rtl/msc_checker.sv
sim/mips_subset_core_unit_tb.sv
